// File: hdl/falling_sand_grid_step_unit_defines.svh
// assertion macros used by the falling sand grid step controller
`ifndef FALLING_SAND_GRID_STEP_UNIT_DEFINES_SVH
`define FALLING_SAND_GRID_STEP_UNIT_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define FSGS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define FSGS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define FSGS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define FSGS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: hdl/fsgs_pkg.sv
package fsgs_pkg;

	localparam int GRID_ROWS = 64;
	localparam int GRID_COLS = 64;
	localparam int CELL_BITS = 2;

	localparam int ROW_W     = $clog2(GRID_ROWS);
	localparam int COL_W     = $clog2(GRID_COLS);
	localparam int ADDR_W    = ROW_W + COL_W;
	localparam int MEM_DEPTH = 1 << ADDR_W;

	localparam int OP_W   = 2;
	localparam int IDX_W  = 6;
	localparam int VAL_W  = 2;
	localparam int GEN_W  = 32;
	localparam int SEED_W = 16;

	localparam logic [SEED_W-1:0] SEED_DEFAULT = 16'd44257;
	localparam logic [SEED_W-1:0] LFSR_TAPS    = 16'hB400;

	localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
	localparam logic [OP_W-1:0] OP_READ    = 2'd1;
	localparam logic [OP_W-1:0] OP_ADVANCE = 2'd2;

	localparam logic CFG_SURFACE_MODE = 1'b0;
	localparam logic CFG_RANDOM_SEED  = 1'b1;

	typedef logic [CELL_BITS-1:0] cell_t;
	typedef logic [ADDR_W-1:0]    addr_t;

	localparam cell_t CELL_EMPTY = cell_t'(0);
	localparam cell_t CELL_SAND  = cell_t'(1);

	typedef struct packed {
		addr_t rd_addr;
		logic  we;
		addr_t wr_addr;
		cell_t wr_data;
	} ram_req_t;

	typedef struct packed {
		logic             valid;
		logic [VAL_W-1:0] read_value;
		logic [GEN_W-1:0] generation_count;
	} res_t;

endpackage

// File: hdl/fsgs_grid_ram.sv
module fsgs_grid_ram
	import fsgs_pkg::*;
(
	input  logic     clk,
	input  ram_req_t req,
	output cell_t    rd_data
);

	cell_t mem [MEM_DEPTH];
	cell_t rd_data_q;

	// read returns the old content when the same entry is written
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		rd_data_q <= mem[req.rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// File: hdl/fsgs_step_ctrl.sv
`include "falling_sand_grid_step_unit_defines.svh"

module fsgs_step_ctrl
	import fsgs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [OP_W-1:0]  operation,
	input  logic [IDX_W-1:0] row_index,
	input  logic [IDX_W-1:0] col_index,
	input  logic [VAL_W-1:0] write_value,
	input  logic             surface_mode,
	input  logic             lfsr_bit,
	output logic             lfsr_step,
	output ram_req_t         ram_req,
	input  cell_t            rd_data,
	output res_t             res,
	input  logic             res_ready
);

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_RDW,
		S_CHK,
		S_BLW,
		S_LFT,
		S_RGT,
		S_RSM,
		S_WR2,
		S_EMIT
	} state_t;

	localparam logic [ROW_W-1:0] ROW_START = ROW_W'(GRID_ROWS - 2);
	localparam logic [COL_W-1:0] COL_LAST  = COL_W'(GRID_COLS - 1);

	state_t             state_q, state_d;
	addr_t              clr_q, clr_d;
	logic [ROW_W-1:0]   row_q, row_d;
	logic [COL_W-1:0]   col_q, col_d;
	logic [COL_W-1:0]   dest_q, dest_d;
	logic               lf_q, lf_d;
	logic               rb_q, rb_d;
	logic               inside_q, inside_d;
	logic [VAL_W-1:0]   rdv_q, rdv_d;
	logic [GEN_W-1:0]   gen_q, gen_d;

	logic               in_inside;
	addr_t              in_addr;
	logic [ROW_W-1:0]   row_dn;
	logic [COL_W-1:0]   col_left, col_right;
	logic               col_last;
	logic [ROW_W-1:0]   nxt_row;
	logic [COL_W-1:0]   nxt_col;
	logic               nxt_done;
	logic               go_next;
	logic               rf;
	logic               move;
	logic [COL_W-1:0]   move_col;

	assign in_inside = (32'(row_index) < GRID_ROWS) && (32'(col_index) < GRID_COLS);
	assign in_addr   = {ROW_W'(row_index), COL_W'(col_index)};
	assign row_dn    = row_q + 1'b1;
	assign col_last  = (col_q == COL_LAST);

	always_comb begin
		if (col_q == '0) begin
			col_left = surface_mode ? COL_LAST : col_q;
		end else begin
			col_left = col_q - 1'b1;
		end
		if (col_last) begin
			col_right = surface_mode ? '0 : col_q;
		end else begin
			col_right = col_q + 1'b1;
		end
	end

	// scan order: left to right, then one row up
	always_comb begin
		nxt_done = 1'b0;
		nxt_row  = row_q;
		nxt_col  = col_q + 1'b1;
		if (col_last) begin
			nxt_col = '0;
			if (row_q == '0) begin
				nxt_done = 1'b1;
			end else begin
				nxt_row = row_q - 1'b1;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		clr_d     = clr_q;
		row_d     = row_q;
		col_d     = col_q;
		dest_d    = dest_q;
		lf_d      = lf_q;
		rb_d      = rb_q;
		inside_d  = inside_q;
		rdv_d     = rdv_q;
		gen_d     = gen_q;
		in_ready  = 1'b0;
		lfsr_step = 1'b0;
		go_next   = 1'b0;
		rf        = 1'b0;
		move      = 1'b0;
		move_col  = col_q;
		ram_req   = '{rd_addr: {row_q, col_q}, we: 1'b0, wr_addr: {row_q, col_q},
			wr_data: CELL_EMPTY};
		res       = '{valid: 1'b0, read_value: rdv_q, generation_count: gen_q};

		case (state_q)
			S_CLEAR: begin
				ram_req.we      = 1'b1;
				ram_req.wr_addr = clr_q;
				ram_req.wr_data = CELL_EMPTY;
				clr_d           = clr_q + 1'b1;
				if (clr_q == '1) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					rdv_d = '0;
					case (operation)
						OP_WRITE: begin
							ram_req.we      = in_inside;
							ram_req.wr_addr = in_addr;
							ram_req.wr_data = cell_t'(write_value);
							state_d         = S_EMIT;
						end
						OP_READ: begin
							ram_req.rd_addr = in_addr;
							inside_d        = in_inside;
							state_d         = S_RDW;
						end
						OP_ADVANCE: begin
							row_d           = ROW_START;
							col_d           = '0;
							ram_req.rd_addr = {ROW_START, COL_W'(0)};
							state_d         = S_CHK;
						end
						default: begin
							state_d = S_EMIT;
						end
					endcase
				end
			end
			S_RDW: begin
				rdv_d   = inside_q ? VAL_W'(rd_data) : '0;
				state_d = S_EMIT;
			end
			S_CHK: begin
				if (rd_data == CELL_SAND) begin
					ram_req.rd_addr = {row_dn, col_q};
					state_d         = S_BLW;
				end else begin
					go_next = 1'b1;
				end
			end
			S_BLW: begin
				if (rd_data == CELL_EMPTY) begin
					move     = 1'b1;
					move_col = col_q;
				end else begin
					ram_req.rd_addr = {row_dn, col_left};
					state_d         = S_LFT;
				end
			end
			S_LFT: begin
				lf_d            = (rd_data == CELL_EMPTY);
				ram_req.rd_addr = {row_dn, col_right};
				state_d         = S_RGT;
			end
			S_RGT: begin
				rb_d            = (rd_data == CELL_EMPTY);
				ram_req.rd_addr = {row_q, col_right};
				state_d         = S_RSM;
			end
			S_RSM: begin
				// a clamped side points back at the sand or the cell below, never free
				rf = rb_q && (rd_data == CELL_EMPTY);
				if (lf_q && rf) begin
					lfsr_step = 1'b1;
					move      = 1'b1;
					move_col  = lfsr_bit ? col_left : col_right;
				end else if (lf_q) begin
					move     = 1'b1;
					move_col = col_left;
				end else if (rf) begin
					move     = 1'b1;
					move_col = col_right;
				end else begin
					go_next = 1'b1;
				end
			end
			S_WR2: begin
				ram_req.we      = 1'b1;
				ram_req.wr_addr = {row_dn, dest_q};
				ram_req.wr_data = CELL_SAND;
				go_next         = 1'b1;
			end
			S_EMIT: begin
				res.valid = 1'b1;
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// empty the sand cell now, fill the target next cycle
		if (move) begin
			ram_req.we      = 1'b1;
			ram_req.wr_addr = {row_q, col_q};
			ram_req.wr_data = CELL_EMPTY;
			dest_d          = move_col;
			state_d         = S_WR2;
		end

		// prefetch the next cell of the scan, or count the generation when the scan is done
		if (go_next) begin
			if (nxt_done) begin
				gen_d   = gen_q + 1'b1;
				state_d = S_EMIT;
			end else begin
				row_d           = nxt_row;
				col_d           = nxt_col;
				ram_req.rd_addr = {nxt_row, nxt_col};
				state_d         = S_CHK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			clr_q    <= '0;
			gen_q    <= '0;
			row_q    <= '0;
			col_q    <= '0;
			dest_q   <= '0;
			lf_q     <= 1'b0;
			rb_q     <= 1'b0;
			inside_q <= 1'b0;
			rdv_q    <= '0;
		end else begin
			state_q  <= state_d;
			clr_q    <= clr_d;
			gen_q    <= gen_d;
			row_q    <= row_d;
			col_q    <= col_d;
			dest_q   <= dest_d;
			lf_q     <= lf_d;
			rb_q     <= rb_d;
			inside_q <= inside_d;
			rdv_q    <= rdv_d;
		end
	end

	`FSGS_ASSERT_NXT(a_accept_leaves_idle, clk, arst_n, in_valid && in_ready, state_q != S_IDLE, "accepted item did not start")
	`FSGS_ASSERT_IMP(a_choice_needs_left, clk, arst_n, lfsr_step, state_q == S_RSM && lf_q, "lfsr stepped without a two-way choice")
	`FSGS_ASSERT_IMP(a_fill_row_below, clk, arst_n, state_q == S_WR2, ram_req.we && ram_req.wr_addr[ADDR_W-1:COL_W] == row_dn, "sand placed outside the row below")

endmodule

// File: hdl/falling_sand_grid_step_unit.sv
// Falling sand grid: a 64 x 64 grid of 2-bit cells held in one single-port-read
// synchronous RAM. Each item writes a cell, reads a cell or advances one
// generation, and yields one result with the read value and the generation count.
// After reset a clearing pass writes every one of the 4096 entries, during which no
// item is taken; configuration writes are taken at any time. A write or an unused
// code goes straight to the result, while a read first waits for the RAM data.
// A generation scans the 4032 cells from the second-to-last row upward; a sand
// cell checks below, below-left, below-right and its right neighbour, and a move
// empties the sand cell, then fills its target. The RAM gives one read per cycle.
// Results wait in an output register, so the next item is taken meanwhile.
module falling_sand_grid_step_unit
	import fsgs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [OP_W-1:0]   operation,
	input  logic [IDX_W-1:0]  row_index,
	input  logic [IDX_W-1:0]  col_index,
	input  logic [VAL_W-1:0]  write_value,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [VAL_W-1:0]  read_value,
	output logic [GEN_W-1:0]  generation_count,
	input  logic              cfg_write_en,
	input  logic              cfg_index,
	input  logic [SEED_W-1:0] cfg_data
);

	logic              surface_mode_q;
	logic [SEED_W-1:0] lfsr_q;
	logic              lfsr_step;
	ram_req_t          ram_req;
	cell_t             rd_data;
	res_t              res;
	logic              res_ready;
	logic              out_valid_q;
	logic [VAL_W-1:0]  read_value_q;
	logic [GEN_W-1:0]  generation_count_q;

	fsgs_grid_ram u_ram (
		.clk     (clk),
		.req     (ram_req),
		.rd_data (rd_data)
	);

	fsgs_step_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.row_index    (row_index),
		.col_index    (col_index),
		.write_value  (write_value),
		.surface_mode (surface_mode_q),
		.lfsr_bit     (lfsr_q[0]),
		.lfsr_step    (lfsr_step),
		.ram_req      (ram_req),
		.rd_data      (rd_data),
		.res          (res),
		.res_ready    (res_ready)
	);

	// galois lfsr, shifts right; a seed write reloads it, zero falls back to default
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			surface_mode_q <= 1'b0;
			lfsr_q         <= SEED_DEFAULT;
		end else begin
			if (cfg_write_en && cfg_index == CFG_SURFACE_MODE) begin
				surface_mode_q <= cfg_data[0];
			end
			if (cfg_write_en && cfg_index == CFG_RANDOM_SEED) begin
				lfsr_q <= (cfg_data != '0) ? cfg_data : SEED_DEFAULT;
			end else if (lfsr_step) begin
				lfsr_q <= (lfsr_q >> 1) ^ (lfsr_q[0] ? LFSR_TAPS : '0);
			end
		end
	end

	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid && res_ready) begin
			read_value_q       <= res.read_value;
			generation_count_q <= res.generation_count;
		end
	end

	assign out_valid        = out_valid_q;
	assign read_value       = read_value_q;
	assign generation_count = generation_count_q;

endmodule
